### src/bnms_pkg.sv
`timescale 1ns / 1ps
package bnms_pkg;
  localparam int CoordW = 16;
  localparam int PixW = 13;
  localparam int AreaW = 28;
  localparam int SumW = 24;
  localparam int SetsW = 7;
  localparam logic [SetsW-1:0] SetsMax = 7'd127;

  localparam logic [1:0] RegOverlap = 2'd0;
  localparam logic [1:0] RegMerge = 2'd1;
  localparam logic [1:0] RegGap = 2'd2;

  typedef logic signed [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t x0;
    pix_t y0;
    pix_t x1;
    pix_t y1;
  } rect_t;

  typedef struct packed {
    logic [15:0] conf;
    logic [3:0] label;
    logic [7:0] color;
  } meta_t;

  typedef struct packed {
    logic signed [7:0][CoordW-1:0] c;
    rect_t rect;
    logic [AreaW-1:0] area;
    meta_t meta;
    logic last;
  } item_t;

  function automatic pix_t floor_pix(input logic signed [CoordW-1:0] v);
    floor_pix = pix_t'(v >>> 4);
  endfunction
endpackage

### src/bnms_ram.sv
`timescale 1ns / 1ps
module bnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/bnms_front.sv
`timescale 1ns / 1ps
module bnms_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0][15:0]     coords,
  input  logic [15:0]          conf,
  input  logic [3:0]           class_label,
  input  logic [7:0]           color_code,
  input  logic                 last_box,
  output logic                 busy,
  output logic                 q_valid,
  output bnms_pkg::item_t      q_item,
  input  logic                 q_pop
);
  import bnms_pkg::*;

  typedef enum logic [0:0] {S_IDLE, S_CALC} state_t;
  state_t state;
  item_t hold;
  logic signed [CoordW-1:0] minx, maxx, miny, maxy;
  logic [PixW-1:0] w, h;
  logic full;

  always_comb begin
    minx = coords[0];
    maxx = coords[0];
    miny = coords[1];
    maxy = coords[1];
    for (int k = 1; k < 4; k++) begin
      if ($signed(coords[2*k]) < minx) minx = coords[2*k];
      if ($signed(coords[2*k]) > maxx) maxx = coords[2*k];
      if ($signed(coords[2*k+1]) < miny) miny = coords[2*k+1];
      if ($signed(coords[2*k+1]) > maxy) maxy = coords[2*k+1];
    end
  end

  assign w = PixW'(hold.rect.x1 - hold.rect.x0);
  assign h = PixW'(hold.rect.y1 - hold.rect.y0);
  assign busy = (state != S_IDLE) || full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full <= 1'b0;
    end else begin
      if (q_pop) full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            hold.c <= coords;
            hold.rect.x0 <= floor_pix(minx);
            hold.rect.y0 <= floor_pix(miny);
            hold.rect.x1 <= floor_pix(maxx) + pix_t'(1);
            hold.rect.y1 <= floor_pix(maxy) + pix_t'(1);
            hold.meta <= '{conf: conf, label: class_label, color: color_code};
            hold.last <= last_box;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          q_item <= '{c: hold.c, rect: hold.rect, area: AreaW'(w) * AreaW'(h),
                      meta: hold.meta, last: hold.last};
          full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q_valid = full;
endmodule

### src/bnms_back.sv
`timescale 1ns / 1ps
module bnms_back #(
  parameter int MaxBoxes = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            thr_ovl,
  input  logic [15:0]            thr_mrg,
  input  logic [15:0]            thr_gap,
  input  logic                   q_valid,
  input  bnms_pkg::item_t        q_item,
  output logic                   q_pop,
  output logic                   idle,
  output logic                   done,
  output logic [7:0][15:0]       q_out,
  output bnms_pkg::meta_t        meta_out,
  output logic                   last_kept
);
  import bnms_pkg::*;
  localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int EntW = $bits(rect_t) + AreaW + $bits(meta_t);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_MUL, S_TST, S_SRD, S_SWR,
    S_KEEP, S_ORD, S_DIV, S_OUT
  } state_t;
  state_t state;

  item_t it;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] j;
  logic keep;

  logic ewe;
  logic [IdxW-1:0] ewa, era;
  logic [EntW-1:0] ewd, erd;
  rect_t krect;
  logic [AreaW-1:0] karea;
  meta_t kmeta;

  logic swe;
  logic [IdxW-1:0] swa, sra;
  logic [8*SumW+SetsW-1:0] swd, srd;
  logic [7:0][SumW-1:0] ssum;
  logic [SetsW-1:0] ssets;

  bnms_ram #(.Width(EntW), .Depth(1 << IdxW)) u_ent (
    .clk(clk), .we(ewe), .waddr(ewa), .wdata(ewd), .raddr(era), .rdata(erd)
  );
  bnms_ram #(.Width(8*SumW+SetsW), .Depth(1 << IdxW)) u_sum (
    .clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd)
  );

  assign {krect, karea, kmeta} = erd;
  assign {ssum, ssets} = srd;

  pix_t ix0, iy0, ix1, iy1;
  logic [PixW-1:0] iw, ih;
  logic ipos;
  logic [AreaW-1:0] inter;
  logic [AreaW:0] uni;
  logic [AreaW+16:0] lhs, rhs_o, rhs_m;
  logic sup, uni_zero;
  logic [16:0] gap;
  logic meta_eq;

  always_comb begin
    ix0 = (it.rect.x0 > krect.x0) ? it.rect.x0 : krect.x0;
    iy0 = (it.rect.y0 > krect.y0) ? it.rect.y0 : krect.y0;
    ix1 = (it.rect.x1 < krect.x1) ? it.rect.x1 : krect.x1;
    iy1 = (it.rect.y1 < krect.y1) ? it.rect.y1 : krect.y1;
    gap = (it.meta.conf > kmeta.conf) ? 17'(it.meta.conf) - 17'(kmeta.conf)
                                      : 17'(kmeta.conf) - 17'(it.meta.conf);
    iw = PixW'(ix1 - ix0);
    ih = PixW'(iy1 - iy0);
    ipos = (ix1 > ix0) && (iy1 > iy0);
    uni = (AreaW+1)'(it.area) + (AreaW+1)'(karea) - (AreaW+1)'(inter);
    sup = uni_zero || (lhs > rhs_o);
  end

  // divider
  logic [SumW-1:0] dnum;
  logic [SumW:0] drem;
  logic [SumW-1:0] dq;
  logic [SumW-1:0] dq_next;
  logic [4:0] dbit;
  logic [2:0] dk;
  logic dneg;
  logic [SumW:0] dtry;
  logic [7:0][15:0] qacc;
  logic signed [SumW-1:0] cur;

  assign cur = ssum[dk];
  assign dtry = {drem[SumW-1:0], dnum[SumW-1]};
  assign dq_next = {dq[SumW-2:0], (dtry >= (SumW+1)'(ssets))};

  assign idle = (state == S_IDLE);
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    ewe = (state == S_KEEP) && keep && (cnt < CntW'(MaxBoxes));
    ewa = cnt[IdxW-1:0];
    ewd = {it.rect, it.area, it.meta};
    era = j;
    sra = j;
    swe = ((state == S_SWR) && (ssets < SetsMax)) || ewe;
    swa = ewe ? cnt[IdxW-1:0] : j;
    if (ewe) begin
      for (int k = 0; k < 8; k++) swd[SetsW + k*SumW +: SumW] = SumW'($signed(it.c[k]));
      swd[SetsW-1:0] = SetsW'(1);
    end else begin
      for (int k = 0; k < 8; k++)
        swd[SetsW + k*SumW +: SumW] = ssum[k] + SumW'($signed(it.c[k]));
      swd[SetsW-1:0] = ssets + SetsW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            j <= '0;
            keep <= 1'b1;
            state <= (cnt == '0) ? S_KEEP : S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          inter <= ipos ? AreaW'(iw) * AreaW'(ih) : '0;
          meta_eq <= (gap < 17'(thr_gap)) && (it.meta.label == kmeta.label)
                     && (it.meta.color == kmeta.color);
          state <= S_MUL;
        end
        S_MUL: begin
          uni_zero <= (uni == '0);
          lhs <= {1'b0, inter, 16'd0};
          rhs_o <= (AreaW+17)'(uni) * (AreaW+17)'(thr_ovl);
          rhs_m <= (AreaW+17)'(uni) * (AreaW+17)'(thr_mrg);
          state <= S_TST;
        end
        S_TST: begin
          if (sup) keep <= 1'b0;
          if (sup && !uni_zero && (lhs > rhs_m) && meta_eq) state <= S_SRD;
          else if (CntW'(j) + 1'b1 == cnt) state <= S_KEEP;
          else begin
            j <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (CntW'(j) + 1'b1 == cnt) state <= S_KEEP;
          else begin
            j <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_KEEP: begin
          if (ewe) cnt <= cnt + 1'b1;
          j <= '0;
          if (it.last && (cnt != '0 || ewe)) state <= S_ORD;
          else begin
            if (it.last) cnt <= '0;
            state <= S_IDLE;
          end
        end
        S_ORD: begin
          dk <= '0;
          state <= S_DIV;
          dbit <= '0;
          drem <= '0;
          dneg <= 1'b0;
        end
        S_DIV: begin
          if (dbit == 5'd0 && drem == '0 && !dneg) begin
            dnum <= cur[SumW-1] ? SumW'(-cur) : SumW'(cur);
            dneg <= 1'b1;
            dbit <= 5'd1;
            drem <= {1'b1, {SumW{1'b0}}};
          end else begin
            if (drem[SumW] && dbit == 5'd1) begin
              drem <= '0;
              dbit <= 5'd2;
            end else begin
              dnum <= dnum << 1;
              if (dtry >= (SumW+1)'(ssets)) begin
                drem <= dtry - (SumW+1)'(ssets);
                dq <= {dq[SumW-2:0], 1'b1};
              end else begin
                drem <= dtry;
                dq <= {dq[SumW-2:0], 1'b0};
              end
              if (dbit == 5'(SumW + 1)) begin
                qacc[dk] <= 16'(cur[SumW-1] ? -dq_next : dq_next);
                dbit <= '0;
                drem <= '0;
                dneg <= 1'b0;
                if (dk == 3'd7) state <= S_OUT;
                else dk <= dk + 1'b1;
              end else begin
                dbit <= dbit + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          q_out <= qacc;
          meta_out <= kmeta;
          last_kept <= (CntW'(j) + 1'b1 == cnt);
          done <= 1'b1;
          if (CntW'(j) + 1'b1 == cnt) begin
            cnt <= '0;
            state <= S_IDLE;
          end else begin
            j <= j + 1'b1;
            state <= S_ORD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CntW'(MaxBoxes))
    else $error("kept count overflow");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_OUT))
    else $error("result without output step");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> state != S_IDLE)
    else $error("popped item not taken");
endmodule

### src/box_nms_with_apex_merge_top.sv
`timescale 1ns / 1ps
// Per item, the compare walk over the kept list takes, per kept box, one BRAM read
// and a registered area/ratio test (CMP, MUL, TST), plus the SRD and SWR states per merge.
// Frame end: 8 serial divides per kept box, one result per kept box.
// Throughput: one item at a time; busy stays high while the compare walk runs.
// Reset (rst, synchronous) clears control state and loads threshold defaults.
// Results are strobed by out_valid for one cycle; the receiver cannot stall.
module box_nms_with_apex_merge_top #(
  parameter int MAX_BOXES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic signed [15:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
  input  logic [15:0] conf,
  input  logic [3:0]  class_label,
  input  logic [7:0]  color_code,
  input  logic        last_box,
  output logic        out_valid,
  output logic signed [15:0] q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
  output logic [15:0] kept_conf,
  output logic [3:0]  kept_label,
  output logic [7:0]  kept_color,
  output logic        last_kept
);
  import bnms_pkg::*;

  logic [15:0] thr_ovl, thr_mrg, thr_gap;
  logic q_valid, q_pop, fbusy, bidle;
  item_t q_item;
  logic [7:0][15:0] qo;
  meta_t mo;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_ovl <= 16'd29491;
      thr_mrg <= 16'd58982;
      thr_gap <= 16'd9830;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOverlap: thr_ovl <= cfg_data;
        RegMerge: thr_mrg <= cfg_data;
        RegGap: thr_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  bnms_front u_front (
    .clk(clk), .rst(rst), .start(start & bidle),
    .coords({p3_y, p3_x, p2_y, p2_x, p1_y, p1_x, p0_y, p0_x}),
    .conf(conf), .class_label(class_label), .color_code(color_code),
    .last_box(last_box), .busy(fbusy), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop)
  );

  bnms_back #(.MaxBoxes(MAX_BOXES)) u_back (
    .clk(clk), .rst(rst), .thr_ovl(thr_ovl), .thr_mrg(thr_mrg), .thr_gap(thr_gap),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .idle(bidle),
    .done(out_valid), .q_out(qo), .meta_out(mo), .last_kept(last_kept)
  );

  assign busy = fbusy || !bidle;
  assign {q3_y, q3_x, q2_y, q2_x, q1_y, q1_x, q0_y, q0_x} = qo;
  assign kept_conf = mo.conf;
  assign kept_label = mo.label;
  assign kept_color = mo.color;
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import bnms_pkg::*;

  localparam int Boxes = 64;
  localparam int MergeCap = 127;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 800;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct {
    int c[8];
    int conf;
    int label;
    int color;
    int last;
  } box_t;

  typedef struct {
    int c[8];
    int conf;
    int label;
    int color;
    int last;
    int self_chk;
  } row_t;

  logic clk, rst, start, busy, cfg_we, last_box, out_valid, last_kept;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data, conf, kept_conf;
  logic signed [15:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic signed [15:0] q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y;
  logic [3:0] class_label, kept_label;
  logic [7:0] color_code, kept_color;

  box_nms_with_apex_merge_top u_top (.*);

  // predictor state
  logic [15:0] ovl_thr, mrg_thr, conf_gap;
  int n_kept;
  int k_rect[Boxes][4];
  longint k_area[Boxes];
  box_t k_meta[Boxes];
  int k_sum[Boxes][8];
  int k_sets[Boxes];

  box_t kept_q[$];
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 0;
  int conf_run = 65535;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int pix(input int v);
    return v >>> 4;
  endfunction

  function automatic bit above(input longint inter, input longint uni, input logic [15:0] thr);
    return (inter << 16) > longint'(thr) * uni;
  endfunction

  task automatic nms_predict(input box_t b);
    int mnx, mxx, mny, mxy, ix0, iy0, ix1, iy1, gap, j, k;
    int r[4];
    longint area, inter, uni;
    bit keep;
    box_t res;
    keep = 1;
    mnx = b.c[0]; mxx = b.c[0]; mny = b.c[1]; mxy = b.c[1];
    for (k = 1; k < 4; k++) begin
      if (b.c[2*k] < mnx) mnx = b.c[2*k];
      if (b.c[2*k] > mxx) mxx = b.c[2*k];
      if (b.c[2*k+1] < mny) mny = b.c[2*k+1];
      if (b.c[2*k+1] > mxy) mxy = b.c[2*k+1];
    end
    r[0] = pix(mnx); r[1] = pix(mny); r[2] = pix(mxx) + 1; r[3] = pix(mxy) + 1;
    area = longint'(r[2] - r[0]) * longint'(r[3] - r[1]);
    for (j = 0; j < n_kept; j++) begin
      ix0 = r[0] > k_rect[j][0] ? r[0] : k_rect[j][0];
      iy0 = r[1] > k_rect[j][1] ? r[1] : k_rect[j][1];
      ix1 = r[2] < k_rect[j][2] ? r[2] : k_rect[j][2];
      iy1 = r[3] < k_rect[j][3] ? r[3] : k_rect[j][3];
      inter = 0;
      if (ix1 > ix0 && iy1 > iy0) inter = longint'(ix1 - ix0) * longint'(iy1 - iy0);
      uni = area + k_area[j] - inter;
      if (uni == 0 || above(inter, uni, ovl_thr)) begin
        keep = 0;
        gap = b.conf - k_meta[j].conf;
        if (gap < 0) gap = -gap;
        if (uni != 0 && above(inter, uni, mrg_thr) && gap < int'(conf_gap) &&
            b.label == k_meta[j].label && b.color == k_meta[j].color &&
            k_sets[j] < MergeCap) begin
          for (k = 0; k < 8; k++) k_sum[j][k] += b.c[k];
          k_sets[j]++;
        end
      end
    end
    if (keep && n_kept < Boxes) begin
      for (k = 0; k < 4; k++) k_rect[n_kept][k] = r[k];
      k_area[n_kept] = area;
      k_meta[n_kept] = b;
      for (k = 0; k < 8; k++) k_sum[n_kept][k] = b.c[k];
      k_sets[n_kept] = 1;
      n_kept++;
    end
    if (b.last) begin
      for (j = 0; j < n_kept; j++) begin
        res = k_meta[j];
        for (k = 0; k < 8; k++) res.c[k] = int'($signed(16'(k_sum[j][k] / k_sets[j])));
        res.last = (j + 1 == n_kept);
        kept_q = {kept_q, res};
      end
      n_kept = 0;
    end
  endtask

  always @(posedge clk) begin
    box_t e;
    int got[8];
    if (!rst && out_valid) begin
      got = '{int'(q0_x), int'(q0_y), int'(q1_x), int'(q1_y),
              int'(q2_x), int'(q2_y), int'(q3_x), int'(q3_y)};
      if (kept_q.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        e = kept_q.pop_front();
        for (int k = 0; k < 8; k++)
          if (got[k] != e.c[k]) report("corner", got[k], e.c[k]);
        if (kept_conf != e.conf) report("kept_conf", kept_conf, e.conf);
        if (kept_label != e.label) report("kept_label", kept_label, e.label);
        if (kept_color != e.color) report("kept_color", kept_color, e.color);
        if (last_kept != e.last) report("last_kept", last_kept, e.last);
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_box(input box_t b);
    int g;
    g = idle_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    {p0_x, p0_y, p1_x, p1_y} <= {16'(b.c[0]), 16'(b.c[1]), 16'(b.c[2]), 16'(b.c[3])};
    {p2_x, p2_y, p3_x, p3_y} <= {16'(b.c[4]), 16'(b.c[5]), 16'(b.c[6]), 16'(b.c[7])};
    conf <= 16'(b.conf);
    class_label <= 4'(b.label);
    color_code <= 8'(b.color);
    last_box <= b.last[0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    nms_predict(b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegOverlap: ovl_thr = val;
      RegMerge: mrg_thr = val;
      RegGap: conf_gap = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [15:0] o, input logic [15:0] m, input logic [15:0] g);
    cfg_write(RegOverlap, o);
    cfg_write(RegMerge, m);
    cfg_write(RegGap, g);
  endtask

  function automatic int clip(input int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic box_t make_rect(input int cx, input int cy, input int w, input int h,
                                     input int jit);
    box_t b;
    int sx[4] = '{-1, 1, 1, -1};
    int sy[4] = '{-1, -1, 1, 1};
    for (int k = 0; k < 4; k++) begin
      b.c[2*k] = clip(cx + sx[k] * w + $urandom_range(0, 2 * jit) - jit);
      b.c[2*k+1] = clip(cy + sy[k] * h + $urandom_range(0, 2 * jit) - jit);
    end
    return b;
  endfunction

  function automatic int next_conf();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    conf_run = conf_run - $urandom_range(0, 2500);
    if (conf_run < 0) conf_run = $urandom_range(0, 65535);
    return conf_run;
  endfunction

  task automatic random_frame();
    int n, cx, cy, w, h, r;
    box_t b, base;
    n = $urandom_range(1, 4);
    no_idle = ($urandom_range(0, 3) == 0);
    conf_run = $urandom_range(20000, 65535);
    cx = $urandom_range(0, 60000) - 30000; cy = $urandom_range(0, 60000) - 30000;
    w = $urandom_range(16, 800); h = $urandom_range(16, 800);
    base.label = $urandom_range(0, 15); base.color = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        for (int k = 0; k < 8; k++) b.c[k] = int'($signed(16'($urandom)));
        b.label = $urandom_range(0, 15); b.color = $urandom_range(0, 255);
      end else begin
        if (r < 40) begin
          cx = $urandom_range(0, 60000) - 30000; cy = $urandom_range(0, 60000) - 30000;
          w = $urandom_range(16, 800); h = $urandom_range(16, 800);
          base.label = $urandom_range(0, 15); base.color = $urandom_range(0, 255);
        end
        b = make_rect(cx, cy, w, h, $urandom_range(0, (w < h ? w : h) / 6));
        b.label = base.label; b.color = base.color;
        if ($urandom_range(0, 6) == 0) b.label = $urandom_range(0, 15);
        if ($urandom_range(0, 6) == 0) b.color = $urandom_range(0, 255);
      end
      b.conf = next_conf();
      b.last = (i == n - 1);
      send_box(b);
    end
    no_idle = 0;
  endtask

  // store overflow: more disjoint one-pixel boxes than the kept list holds
  task automatic full_frame();
    box_t b;
    for (int i = 0; i < Boxes + 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        b.c[2*k] = -20000 + i * 48;
        b.c[2*k+1] = 1000;
      end
      b.conf = 65535 - i; b.label = i % 16; b.color = i;
      b.last = (i == Boxes + 3);
      send_box(b);
    end
  endtask

  // nearly identical boxes (corners moved by at most one unit per box) until the merge set count saturates
  task automatic saturate_frame();
    box_t b;
    b = make_rect(5000, -7000, 300, 200, 0);
    b.label = 9; b.color = 8'hA5; b.conf = 40000;
    for (int i = 0; i < MergeCap + 3; i++) begin
      for (int k = 0; k < 8; k++) b.c[k] = clip(b.c[k] + $urandom_range(0, 2) - 1);
      b.last = (i == MergeCap + 2);
      send_box(b);
    end
  endtask

  row_t dir_rows[] = '{
    '{'{16, 32, 160, 32, 160, 200, 16, 200}, 60000, 3, 8'h55, 1, 1},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 0, 0, 0, 1, 1},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 65535, 15, 255, 1, 1},
    '{'{-160, -160, 160, -160, 160, 160, -160, 160}, 65535, 2, 7, 0, 0},
    '{'{-158, -161, 162, -159, 161, 158, -160, 163}, 64000, 2, 7, 0, 0},
    '{'{-150, -150, 150, -150, 150, 150, -150, 150}, 63000, 2, 7, 0, 0},
    '{'{-159, -160, 161, -160, 160, 161, -160, 160}, 62000, 3, 7, 0, 0},
    '{'{-160, -160, 160, -160, 160, 160, -160, 160}, 61000, 2, 8, 0, 0},
    '{'{-160, -160, 160, -160, 160, 160, -160, 160}, 1000, 2, 7, 0, 0},
    '{'{4000, 4000, 4800, 4000, 4800, 4800, 4000, 4800}, 60000, 5, 1, 0, 0},
    '{'{4000, 4000, 4800, 4100, 4700, 4900, 3950, 4800}, 65000, 5, 1, 0, 0},
    '{'{-1, -1, 0, -1, 0, 0, -1, 0}, 30000, 1, 2, 0, 0},
    '{'{-17, 15, 17, 15, -17, -15, 17, -15}, 20000, 1, 2, 0, 0},
    '{'{32767, -32768, -32768, 32767, 0, 0, 100, -100}, 10000, 4, 9, 1, 0},
    '{'{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767}, 50000, 6, 6, 0, 0},
    '{'{100, 100, 116, 100, 116, 116, 100, 116}, 40000, 6, 6, 1, 0}
  };

  initial begin
    box_t b;
    box_t r;
    start <= 1'b0; cfg_we <= 1'b0; cfg_index <= RegOverlap; cfg_data <= 16'd0;
    {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} <= '0;
    conf <= 16'd0; class_label <= 4'd0; color_code <= 8'd0; last_box <= 1'b0;
    ovl_thr = 16'd29491; mrg_thr = 16'd58982; conf_gap = 16'd9830; n_kept = 0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      b.c = dir_rows[i].c; b.conf = dir_rows[i].conf; b.label = dir_rows[i].label;
      b.color = dir_rows[i].color; b.last = dir_rows[i].last;
      send_box(b);
      if (dir_rows[i].self_chk) begin
        r = kept_q[kept_q.size() - 1];
        r.c = dir_rows[i].c;
        r.conf = dir_rows[i].conf; r.label = dir_rows[i].label;
        r.color = dir_rows[i].color; r.last = 1;
        kept_q[kept_q.size() - 1] = r;
      end
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: cfg_write(RegUnused, 16'h1234);
        1: set_thresholds(16'd0, 16'd0, 16'hFFFF);
        2: set_thresholds(16'hFFFF, 16'hFFFF, 16'd0);
        3: set_thresholds(16'd29491, 16'd58982, 16'd9830);
        default: set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
      endcase
      for (int f = 0; f < 2; f++) begin
        random_frame();
        if (f == 0) drain();
      end
      if (phase == 0) full_frame();
      if (phase == 3) saturate_frame();
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### box_nms_with_apex_merge_top.f
src/bnms_pkg.sv
src/bnms_ram.sv
src/bnms_front.sv
src/bnms_back.sv
src/box_nms_with_apex_merge_top.sv
verif/tb.sv
